[rtl/sri_pkg.sv]
// ----------------------------------------------------------------------------
// Subset rank index package
// Shared widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package sri_pkg;

    localparam int MASK_W     = 32;
    localparam int RANK_W     = 30;
    localparam int SIZE_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [SIZE_W-1:0] SET_SIZE_RST    = 6'd8;
    localparam logic [SIZE_W-1:0] SUBSET_SIZE_RST = 6'd4;
    localparam logic              ORDER_MODE_RST  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SET_SIZE    = 2'd0,
        CFG_SUBSET_SIZE = 2'd1,
        CFG_ORDER_MODE  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_FILL   = 3'd0,
        S_IDLE   = 3'd1,
        S_COUNT  = 3'd2,
        S_SETUP  = 3'd3,
        S_SCAN   = 3'd4,
        S_DRAIN  = 3'd5,
        S_FINISH = 3'd6
    } t_state;

endpackage

[rtl/sri_cfg_if.sv]
// ----------------------------------------------------------------------------
// Subset rank index configuration channel
// Register write channel: index and data under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sri_cfg_if;
    import sri_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/sri_in_if.sv]
// ----------------------------------------------------------------------------
// Subset rank index input channel
// Carries one membership mask per transaction.
// ----------------------------------------------------------------------------
interface sri_in_if;
    import sri_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] member_mask;

    modport source (output valid, output member_mask, input ready);
    modport sink   (input valid, input member_mask, output ready);
endinterface

[rtl/sri_out_if.sv]
// ----------------------------------------------------------------------------
// Subset rank index output channel
// Carries the rank and the found flag of one query per transaction.
// ----------------------------------------------------------------------------
interface sri_out_if;
    import sri_pkg::*;

    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank_index;
    logic              found;

    modport source (output valid, output rank_index, output found, input ready);
    modport sink   (input valid, input rank_index, input found, output ready);
endinterface

[rtl/subset_rank_index_top.sv]
// ----------------------------------------------------------------------------
// Subset rank index
// Lexicographic rank of the first k-subset of n elements that covers a mask.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                   transaction
//  -------  ---  ------------------------  ---------------------------
//  i_cfg    in   index[1:0], data[5:0]     valid & ready (ready held high)
//  i_in     in   member_mask[31:0]         valid & ready
//  o_out    out  rank_index[29:0], found   valid & ready
//
//  After reset a fill pass builds Pascal's triangle mod 2^30 in a binomial RAM,
//  with input ready low meanwhile. A query runs a byte-wise popcount and then,
//  unless k > n, the mask holds more than k members or n is zero, steps one
//  element per cycle through the single RAM read port and the rank accumulator.
//  A finished result waits in the output register while the next query runs;
//  only a second result with the first still untaken stalls the sequencer.
// ----------------------------------------------------------------------------
module subset_rank_index_top #(
    parameter int MAX_ELEMENTS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sri_cfg_if.sink   i_cfg,
    sri_in_if.sink    i_in,
    sri_out_if.source o_out
);
    import sri_pkg::*;

    localparam int AW    = $clog2(MAX_ELEMENTS + 1);
    localparam int IW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int EW    = (MAX_ELEMENTS > MASK_W) ? MAX_ELEMENTS : MASK_W;
    localparam int NB    = (MAX_ELEMENTS + 7) / 8;
    localparam int SW    = NB * 8;
    localparam int BW    = (NB > 1) ? $clog2(NB) : 1;
    localparam int DEPTH = 1 << (2 * AW);

    localparam logic [AW-1:0] M_AW    = AW'(MAX_ELEMENTS);
    localparam logic [BW-1:0] BC_LAST = BW'(NB - 1);

    // configuration
    logic [SIZE_W-1:0] r_set_size;
    logic [SIZE_W-1:0] r_subset_size;
    logic              r_order_mode;

    // sequencer
    t_state r_state;
    t_state n_state;

    // binomial RAM
    logic [RANK_W-1:0] r_binom [0:DEPTH-1];
    logic [RANK_W-1:0] r_rd;
    logic [2*AW-1:0]   w_raddr;
    logic [RANK_W-1:0] w_wdata;
    logic [AW-1:0]     r_fa;
    logic [AW-1:0]     r_fb;
    logic              r_wp;
    logic [AW-1:0]     r_wa;
    logic [AW-1:0]     r_wb;
    logic [RANK_W-1:0] r_prev;

    // query datapath
    logic [AW-1:0]             w_n_cfg;
    logic [EW-1:0]             w_mask_ext;
    logic [MAX_ELEMENTS-1:0]   w_mask_n;
    logic [MAX_ELEMENTS-1:0]   r_vec;
    logic [SW-1:0]             r_scan;
    logic [BW-1:0]             r_bc;
    logic [3:0]                w_pop;
    logic [AW-1:0]             r_cnt;
    logic [AW-1:0]             r_n;
    logic [SIZE_W-1:0]         r_k;
    logic                      r_mode;
    logic [IW-1:0]             r_i;
    logic [AW-1:0]             r_j;
    logic [AW-1:0]             r_s;
    logic [AW-1:0]             r_t;
    logic [AW-1:0]             r_extra;
    logic                      w_m;
    logic                      w_fill;
    logic                      w_bit;
    logic [AW-1:0]             w_t_new;
    logic                      w_k_gt;
    logic                      w_cnt_gt;
    logic                      w_special;
    logic                      r_acc_v;
    logic [RANK_W-1:0]         r_rank;
    logic [RANK_W-1:0]         r_total;
    logic                      r_spec;
    logic [RANK_W-1:0]         r_res;
    logic                      r_found;
    logic [RANK_W-1:0]         w_final;

    // handshakes
    logic              w_in_ready;
    logic              w_in_acc;
    logic              w_load_out;
    logic              r_ov;
    logic [RANK_W-1:0] r_orank;
    logic              r_ofound;

    assign i_cfg.ready      = 1'b1;
    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = r_ov;
    assign o_out.rank_index = r_orank;
    assign o_out.found      = r_ofound;
    assign w_in_acc         = i_in.valid && w_in_ready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_size    <= SET_SIZE_RST;
            r_subset_size <= SUBSET_SIZE_RST;
            r_order_mode  <= ORDER_MODE_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_SET_SIZE:    r_set_size    <= i_cfg.data[SIZE_W-1:0];
                CFG_SUBSET_SIZE: r_subset_size <= i_cfg.data[SIZE_W-1:0];
                CFG_ORDER_MODE:  r_order_mode  <= i_cfg.data[0];
                default: begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Query datapath (combinational part)
    // ------------------------------------------------------------------
    always_comb begin
        w_n_cfg = (7'(r_set_size) > 7'(MAX_ELEMENTS)) ? M_AW : AW'(r_set_size);
        w_mask_ext = EW'(i_in.member_mask);
        for (int e = 0; e < MAX_ELEMENTS; e++) begin
            w_mask_n[e] = w_mask_ext[e] && (7'(e) < 7'(w_n_cfg));
        end

        w_pop = '0;
        for (int b = 0; b < 8; b++) begin
            w_pop = w_pop + 4'(r_scan[b]);
        end

        w_m = r_vec[r_i];
        // ascending: extras go as late as possible, i.e. first on a downward scan;
        // descending: a hole takes an extra while fewer holes lie below it
        w_fill  = !w_m && (r_mode ? (r_extra != '0)
                                  : ((8'(r_i) + 8'(r_s)) < 8'(r_k)));
        w_bit   = w_m || w_fill;
        w_t_new = r_t + AW'(w_bit);

        w_k_gt    = 7'(r_k) > 7'(r_n);
        w_cnt_gt  = 7'(r_cnt) > 7'(r_k);
        w_special = w_k_gt || w_cnt_gt || (r_n == '0);

        w_final = r_spec ? r_res
                         : (r_mode ? r_rank : (r_total - r_rank - RANK_W'(1)));

        // Pascal recurrence; row 0 is the unit row
        if (r_wa == '0) begin
            w_wdata = (r_wb == '0) ? RANK_W'(1) : '0;
        end else begin
            w_wdata = r_rd + ((r_wb == '0) ? '0 : r_prev);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_FILL: begin
                if (r_fa == M_AW && r_fb == M_AW) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in.valid) n_state = S_COUNT;
            end
            S_COUNT: begin
                if (r_bc == '0) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = w_special ? S_FINISH : S_SCAN;
            end
            S_SCAN: begin
                if (r_i == '0) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_ov || o_out.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        w_in_ready = 1'b0;
        w_load_out = 1'b0;
        w_raddr    = '0;
        unique case (r_state)
            S_FILL:   w_raddr = {r_fa - AW'(1), r_fb};
            S_IDLE:   w_in_ready = 1'b1;
            S_COUNT:  w_raddr = {r_n, AW'(r_k)};
            S_SETUP:  w_raddr = '0;
            S_SCAN:   w_raddr = {r_j, w_t_new};
            S_DRAIN:  w_raddr = '0;
            S_FINISH: w_load_out = !r_ov || o_out.ready;
            default:  w_raddr = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Binomial RAM: one write port (fill), one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_wp) begin
            r_binom[{r_wa, r_wb}] <= w_wdata;
        end
        r_rd <= r_binom[w_raddr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
            r_fa    <= '0;
            r_fb    <= '0;
            r_wp    <= 1'b0;
            r_acc_v <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= (r_state == S_FILL);
            r_acc_v <= (r_state == S_SCAN) && w_bit;
            if (r_state == S_FILL) begin
                if (r_fb == M_AW) begin
                    r_fb <= '0;
                    r_fa <= r_fa + AW'(1);
                end else begin
                    r_fb <= r_fb + AW'(1);
                end
            end
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_wa <= r_fa;
        r_wb <= r_fb;
        if (r_wp) r_prev <= r_rd;

        if (w_in_acc) begin
            r_vec  <= w_mask_n;
            r_scan <= SW'(w_mask_n);
            r_bc   <= BC_LAST;
            r_cnt  <= '0;
            r_n    <= w_n_cfg;
            r_k    <= r_subset_size;
            r_mode <= r_order_mode;
        end

        if (r_state == S_COUNT) begin
            r_cnt  <= r_cnt + AW'(w_pop);
            r_scan <= r_scan >> 8;
            r_bc   <= r_bc - BW'(1);
        end

        if (r_state == S_SETUP) begin
            r_total <= r_rd;
            r_spec  <= w_special;
            r_res   <= w_cnt_gt ? r_rd : '0;
            r_found <= !w_cnt_gt;
            r_i     <= IW'(r_n - AW'(1));
            r_j     <= '0;
            r_s     <= '0;
            r_t     <= '0;
            r_extra <= AW'(r_k - SIZE_W'(r_cnt));
        end

        if (r_state == S_SCAN) begin
            r_i <= r_i - IW'(1);
            r_j <= r_j + AW'(1);
            r_s <= r_s + AW'(w_m);
            r_t <= w_t_new;
            if (w_fill && r_mode) r_extra <= r_extra - AW'(1);
        end

        // add the binomial fetched for the previous scan step
        if (r_state == S_SETUP) begin
            r_rank <= '0;
        end else if (r_acc_v) begin
            r_rank <= r_rank + r_rd;
        end

        if (w_load_out) begin
            r_orank  <= w_final;
            r_ofound <= r_found;
        end
    end

`ifndef ASSERT_OFF
    a_scan_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ((7'(r_i) + 7'(r_j) + 7'd1) == 7'(r_n)))
        else $error("scan position and binomial row out of step");

    a_acc_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_v |-> $past(r_state == S_SCAN))
        else $error("rank accumulate outside a scan");

    a_members_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (7'(r_t) <= 7'(r_k)))
        else $error("subset holds more members than its size");
`endif

endmodule

[verif/tb_subset_rank_index_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Subset rank index testbench
// Drives membership masks under several listing settings and checks each rank
// and found flag against a local predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_subset_rank_index_top;
    import sri_pkg::*;

    localparam int MAX_ELEMENTS   = 32;
    localparam int RUN_LIMIT      = 2_000_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 60;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int RANDOM_QUERIES = 1850;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct {
        logic [MASK_W-1:0] query_mask;
        logic [RANK_W-1:0] rank_index;
        logic              found;
    } t_rank_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sri_cfg_if cfg_if ();
    sri_in_if  in_if ();
    sri_out_if out_if ();

    subset_rank_index_top #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Local copy of the listing settings
    logic [SIZE_W-1:0] cfg_set_size;
    logic [SIZE_W-1:0] cfg_subset_size;
    logic              cfg_ascending;

    t_rank_result pending_ranks[$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    logic         idle_on = 1'b0;
    logic         hold_off_req = 1'b0;
    logic         hold_off_seen = 1'b0;
    int           hold_off_left = 0;
    int           stall_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: run limit reached, %0d results outstanding", $realtime,
                     pending_ranks.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic longint unsigned count_subsets(int unsigned a, int unsigned b);
        longint unsigned r;
        int unsigned     i;
        r = 1;
        if (b > a)
            return 0;
        if (b > a - b)
            b = a - b;
        for (i = 0; i < b; i++)
            r = r * (a - i) / (i + 1);
        return r;
    endfunction

    function automatic t_rank_result predict_rank(input logic [MASK_W-1:0] query);
        int unsigned     n;
        int unsigned     k;
        int unsigned     cnt;
        int unsigned     extra;
        int unsigned     rem;
        int unsigned     pos;
        int unsigned     i;
        logic [63:0]     vec;
        longint unsigned total;
        longint unsigned rank;
        t_rank_result    res;
        n     = (cfg_set_size > MAX_ELEMENTS) ? MAX_ELEMENTS : cfg_set_size;
        k     = cfg_subset_size;
        vec   = {32'd0, query} & ((64'd1 << n) - 64'd1);
        cnt   = $countones(vec);
        total = count_subsets(n, k);
        res.query_mask = query;
        res.found      = 1'b1;
        if (k > n) begin
            rank = 0;
        end else if (cnt > k) begin
            rank      = total;
            res.found = 1'b0;
        end else begin
            // Place the missing members as late as possible when ascending,
            // as early as possible when descending
            extra = k - cnt;
            for (i = 0; i < n && extra > 0; i++) begin
                pos = cfg_ascending ? (n - 1 - i) : i;
                if (!vec[pos]) begin
                    vec[pos] = 1'b1;
                    extra--;
                end
            end
            rank = 0;
            rem  = k;
            for (i = 0; i < n; i++) begin
                if (vec[i]) begin
                    rank += count_subsets(n - 1 - i, rem);
                    rem--;
                end
            end
            if (!cfg_ascending)
                rank = total - 1 - rank;
        end
        res.rank_index = rank[RANK_W-1:0];
        return res;
    endfunction

    // Output side: check each transaction, then choose the next ready
    always @(posedge i_clk) begin
        t_rank_result want;
        int           gap;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_ranks.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                $display("%0t: unexpected result rank %0d found %0b", $realtime,
                         out_if.rank_index, out_if.found);
            end else begin
                want = pending_ranks.pop_front();
                if (out_if.rank_index !== want.rank_index || out_if.found !== want.found) begin
                    mismatch_count <= mismatch_count + 1;
                    $display("%0t: mask %h n %0d k %0d asc %0b:", $realtime,
                             want.query_mask, cfg_set_size, cfg_subset_size,
                             cfg_ascending,
                             " expected rank %0d found %0b, got rank %0d found %0b",
                             want.rank_index, want.found,
                             out_if.rank_index, out_if.found);
                end
            end
        end
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen <= hold_off_req;
            hold_off_left <= HOLD_OFF_LEN - 1;
            out_if.ready  <= 1'b0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
            out_if.ready  <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_if.ready <= 1'b0;
        end else if (idle_on) begin
            gap = rand_gap();
            if (gap > 0) begin
                stall_left   <= gap - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    task automatic send_query(input logic [MASK_W-1:0] query);
        int gap;
        gap = idle_on ? rand_gap() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.member_mask <= query;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        pending_ranks = {pending_ranks, predict_rank(query)};
    endtask

    // Drop valid and wait until every transaction has come back
    task automatic settle_block();
        in_if.valid <= 1'b0;
        while (pending_ranks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge i_clk);
        while (!cfg_if.ready);
        case (idx)
            CFG_SET_SIZE:    cfg_set_size    = value;
            CFG_SUBSET_SIZE: cfg_subset_size = value;
            CFG_ORDER_MODE:  cfg_ascending   = value[0];
            default: ;
        endcase
    endtask

    task automatic set_listing(input int unsigned n, input int unsigned k,
                               input logic [CFG_DATA_W-1:0] mode);
        settle_block();
        write_reg(CFG_SET_SIZE, n[CFG_DATA_W-1:0]);
        write_reg(CFG_SUBSET_SIZE, k[CFG_DATA_W-1:0]);
        write_reg(CFG_ORDER_MODE, mode);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [MASK_W-1:0] gen_query(input int unsigned n,
                                                    input int unsigned k);
        logic [MASK_W-1:0] m;
        int unsigned       nn;
        int unsigned       want;
        int unsigned       kind;
        nn   = (n > MAX_ELEMENTS) ? MAX_ELEMENTS : n;
        kind = $urandom_range(0, 99);
        if (kind < 12 || nn == 0)
            return $urandom();
        if (kind < 16)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        want = $urandom_range(0, (k < nn) ? k : nn);
        // Now and then one member too many
        if (kind < 26 && k < nn)
            want = k + 1;
        m = '0;
        while ($countones(m) < want)
            m[$urandom_range(0, nn - 1)] = 1'b1;
        // Bits beyond the base set must not matter
        if (nn < MAX_ELEMENTS && $urandom_range(0, 2) == 0)
            m |= $urandom() & ~((32'd1 << nn) - 32'd1);
        return m;
    endfunction

    task automatic test_reset_values();
        send_query('0);
        send_query(32'h0000_000F);
        send_query(32'h0000_00FF);
        send_query(32'hFFFF_FF21);
    endtask

    task automatic test_listing_extremes();
        set_listing(32, 16, 6'd1);
        send_query('0);
        send_query('1);
        send_query(32'h0000_FFFF);
        send_query(32'h8000_0001);
        set_listing(32, 16, 6'd0);
        send_query('0);
        send_query(32'h5555_5555);
        send_query(32'hAAAA_AAAA);
        send_query(32'hFFFF_0000);
        // Empty base set: only the empty subset is listed
        set_listing(0, 0, 6'd1);
        send_query('1);
        set_listing(1, 1, 6'd0);
        send_query('0);
        send_query(32'h0000_0001);
        // Oversized set saturates
        set_listing(63, 32, 6'd0);
        send_query('0);
        // Subset larger than the set
        set_listing(5, 7, 6'd1);
        send_query(32'h0000_0003);
        set_listing(20, 0, 6'd0);
        send_query('0);
        send_query(32'h0000_0001);
        set_listing(32, 63, 6'd1);
        send_query('0);
        // Write to an unused index must change nothing
        settle_block();
        write_reg(CFG_UNUSED_IDX, '1);
        cfg_if.valid <= 1'b0;
        send_query(32'h0001_0000);
    endtask

    task automatic test_random_queries();
        int          sent;
        int          phase_len;
        int          r;
        int unsigned n;
        int unsigned k;
        int unsigned nn;
        int          i;
        sent = 0;
        while (sent < RANDOM_QUERIES) begin
            r = $urandom_range(0, 99);
            if (r < 40)
                n = $urandom_range(1, 12);
            else if (r < 60)
                n = $urandom_range(13, 31);
            else if (r < 85)
                n = MAX_ELEMENTS;
            else if (r < 95)
                n = $urandom_range(33, 63);
            else
                n = 0;
            nn = (n > MAX_ELEMENTS) ? MAX_ELEMENTS : n;
            r  = $urandom_range(0, 99);
            if (r < 60)
                k = $urandom_range(0, nn);
            else if (r < 75)
                k = nn / 2;
            else if (r < 90 && nn < 63)
                k = $urandom_range(nn + 1, 63);
            else
                k = $urandom_range(0, 63);
            set_listing(n, k, {5'($urandom()), 1'($urandom())});
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(10, 60);
            for (i = 0; i < phase_len; i++)
                send_query(gen_query(n, k));
            sent += phase_len;
        end
    endtask

    task automatic test_output_hold();
        int i;
        set_listing(32, 16, 6'd1);
        idle_on = 1'b0;
        // Hold the output off while the input keeps offering transactions
        hold_off_req <= ~hold_off_req;
        for (i = 0; i < 30; i++)
            send_query(gen_query(32, 16));
    endtask

    task automatic test_sender_pause();
        int i;
        set_listing(12, 5, 6'd0);
        idle_on = 1'b1;
        for (i = 0; i < 10; i++)
            send_query(gen_query(12, 5));
        settle_block();
        for (i = 0; i < 10; i++)
            send_query(gen_query(12, 5));
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_SET_SIZE;
        cfg_if.data       <= '0;
        in_if.valid       <= 1'b0;
        in_if.member_mask <= '0;
        cfg_set_size       = SET_SIZE_RST;
        cfg_subset_size    = SUBSET_SIZE_RST;
        cfg_ascending      = ORDER_MODE_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_listing_extremes();
        test_random_queries();
        test_output_hold();
        test_sender_pause();

        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
